### rtl/wisd_pkg.sv
// ----------------------------------------------------------------------------
// wisd_pkg
// Shared types and constants for the windowed interval deviation block.
// ----------------------------------------------------------------------------
package wisd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT    = 3'd3;

    localparam logic [15:0] RST_MIN_INTERVAL = 16'd1000;
    localparam logic [15:0] RST_MAX_INTERVAL = 16'd20000;
    localparam logic [26:0] RST_WINDOW       = 27'd300000;
    localparam logic [9:0]  RST_MIN_COUNT    = 10'd10;

    localparam logic [9:0]  CNT_SAT = 10'd1023;
    localparam logic [23:0] SD_SAT  = 24'hFFFFFF;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] interval_ms;
        logic [47:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  window_count;
        logic [23:0] std_dev_q8;
        logic        std_valid;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL1,
        ST_MUL2,
        ST_NUM,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic push;
        logic start;
        logic walk;
        logic mul1;
        logic mul2;
        logic num;
        logic div;
        logic sqrt;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic calc_ok;
        logic div_last;
        logic sqrt_last;
    } status_t;

endpackage

### rtl/windowed_interval_std_dev.sv
// ----------------------------------------------------------------------------
// windowed_interval_std_dev
// Sliding time-window sample standard deviation of breath intervals.
// ----------------------------------------------------------------------------
//
//  channel  | signals                        | moves
//  ---------+--------------------------------+----------------------------
//  in       | in_valid/in_ready, in_data     | push or measure transaction
//  out      | out_valid/out_ready, out_data  | one result per measure
//  cfg      | cfg_we, cfg_index, cfg_data    | register write, no wait
//
//  Push: accepted while idle, ready stays high, no result.
//  Measure: window walk (one ring read per cycle, registered RAM output),
//  then the MUL1, MUL2 and NUM states, the bit-serial divider and the
//  root, with CW = clog2(SAMPLE_DEPTH+1) setting their widths; divide and
//  root are skipped unless n reaches both two and the minimum count.
//  Reset clears pointers, fill count, sequencer and config registers; the ring
//  itself is never cleared since only written entries are walked.
//  A waiting result does not block new transactions; a finished measure
//  holds in its last state until the output register is free.
//
module windowed_interval_std_dev #(
    parameter int SAMPLE_DEPTH = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wisd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wisd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  wisd_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output wisd_pkg::out_item_t             out_data
);
    import wisd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    wisd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.operation),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // ring, sums, divide and root
    wisd_dp #(
        .DEPTH (SAMPLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

### rtl/wisd_ctrl.sv
// ----------------------------------------------------------------------------
// wisd_ctrl
// Sequencer: walk, multiply, divide and root (skipped when too few samples), then hand the result out.
// ----------------------------------------------------------------------------
module wisd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  wisd_pkg::status_t status,
    output wisd_pkg::cmd_t    cmd
);
    import wisd_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && in_op == OP_MEASURE) state_next = ST_WALK;
            ST_WALK: if (status.walk_done) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_NUM;
            ST_NUM:  state_next = status.calc_ok ? ST_DIV : ST_DONE;
            ST_DIV:  if (status.div_last) state_next = ST_SQRT;
            ST_SQRT: if (status.sqrt_last) state_next = ST_DONE;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.push     = accept && in_op == OP_PUSH;
        cmd.start    = accept && in_op == OP_MEASURE;
        cmd.walk     = (state_reg == ST_WALK);
        cmd.mul1     = (state_reg == ST_MUL1);
        cmd.mul2     = (state_reg == ST_MUL2);
        cmd.num      = (state_reg == ST_NUM);
        cmd.div      = (state_reg == ST_DIV);
        cmd.sqrt     = (state_reg == ST_SQRT);
        cmd.load_out = (state_reg == ST_DONE) && slot_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/wisd_dp.sv
// ----------------------------------------------------------------------------
// wisd_dp
// Sample ring, window sums, restoring divider and digit-by-digit root.
// ----------------------------------------------------------------------------
module wisd_dp #(
    parameter int DEPTH = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wisd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wisd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wisd_pkg::in_item_t                  in_data,
    input  wisd_pkg::cmd_t                      cmd,
    output wisd_pkg::status_t                   status,
    output wisd_pkg::out_item_t                 out_data
);
    import wisd_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int S1W  = 16 + CW;
    localparam int S2W  = 32 + CW;
    localparam int PLW  = 32 + CW;
    localparam int DENW = 2 * CW;
    localparam int NUMW = 32 + 2 * CW;
    localparam int DVW  = NUMW + 16;
    localparam int RW   = DVW / 2;
    localparam int SW   = $clog2(DVW + 1);
    localparam int MW   = (CW > 10) ? CW : 10;

    // configuration
    logic [15:0] min_iv_reg, max_iv_reg;
    logic [26:0] window_reg;
    logic [9:0]  min_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_iv_reg  <= RST_MIN_INTERVAL;
            max_iv_reg  <= RST_MAX_INTERVAL;
            window_reg  <= RST_WINDOW;
            min_cnt_reg <= RST_MIN_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_INTERVAL: min_iv_reg  <= cfg_data[15:0];
                REG_MAX_INTERVAL: max_iv_reg  <= cfg_data[15:0];
                REG_WINDOW:       window_reg  <= cfg_data[26:0];
                REG_MIN_COUNT:    min_cnt_reg <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    // ring pointers
    logic [AW-1:0] wp_reg;
    logic [CW-1:0] fill_reg;
    logic          push_ok;

    assign push_ok = cmd.push && in_data.interval_ms >= min_iv_reg
                     && in_data.interval_ms <= max_iv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (push_ok)
        begin
            wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (fill_reg != CW'(DEPTH))
                fill_reg <= fill_reg + CW'(1);
        end
    end

    // sample memory: {interval, stamp}
    logic [63:0]   mem [DEPTH];
    logic [63:0]   mem_q_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_addr;
    logic          issue;

    assign rd_addr = (rd_ptr_reg == '0) ? AW'(DEPTH - 1) : rd_ptr_reg - AW'(1);

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[wp_reg] <= {in_data.interval_ms, in_data.now_ms};
        if (issue)
            mem_q_reg <= mem[rd_addr];
    end

    // window walk, one read issued per cycle
    logic [47:0]    cutoff_reg;
    logic [CW-1:0]  issued_reg, n_reg;
    logic           pend_reg;
    logic [S1W-1:0] s1_reg;
    logic [S2W-1:0] s2_reg;
    logic [15:0]    x;
    logic [31:0]    xsq;
    logic           stop_now, take;

    assign x        = mem_q_reg[63:48];
    assign xsq      = x * x;
    assign stop_now = pend_reg && (mem_q_reg[47:0] < cutoff_reg);
    assign take     = cmd.walk && pend_reg && !stop_now;
    assign issue    = cmd.walk && !stop_now && (issued_reg != fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (cmd.start)
            pend_reg <= 1'b0;
        else if (cmd.walk)
            pend_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cutoff_reg <= (in_data.now_ms > {21'd0, window_reg})
                          ? in_data.now_ms - {21'd0, window_reg} : 48'd0;
            rd_ptr_reg <= wp_reg;
            issued_reg <= '0;
            n_reg      <= '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
        end
        else
        begin
            if (issue)
            begin
                rd_ptr_reg <= rd_addr;
                issued_reg <= issued_reg + CW'(1);
            end
            if (take)
            begin
                n_reg  <= n_reg + CW'(1);
                s1_reg <= s1_reg + S1W'(x);
                s2_reg <= s2_reg + S2W'(xsq);
            end
        end
    end

    // n*S2 - S1^2 and n*(n-1); n*S2 split at bit 32
    logic [PLW-1:0]  p_lo_reg;
    logic [NUMW-1:0] sq_reg;
    logic [DENW-1:0] p_hi_reg, den_reg;
    logic [NUMW-1:0] num;
    logic            ok_reg;

    assign num = NUMW'(p_lo_reg) + (NUMW'(p_hi_reg) << 32) - sq_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            p_lo_reg <= PLW'(n_reg) * PLW'(s2_reg[31:0]);
            sq_reg   <= NUMW'(s1_reg) * NUMW'(s1_reg);
        end
        if (cmd.mul2)
        begin
            p_hi_reg <= DENW'(n_reg) * DENW'(s2_reg[S2W-1:32]);
            den_reg  <= DENW'(n_reg) * DENW'(n_reg - CW'(1));
        end
        if (cmd.num)
            ok_reg <= (MW'(n_reg) >= MW'(min_cnt_reg));
    end

    assign status.walk_done = cmd.walk
                              && (stop_now || (!pend_reg && issued_reg == fill_reg));
    assign status.calc_ok   = (MW'(n_reg) >= MW'(min_cnt_reg)) && (n_reg >= CW'(2));

    // divider then root, sharing the shift register and step counter
    logic [DVW-1:0]  dvd_reg;
    logic [DENW:0]   rem_reg;
    logic [SW-1:0]   step_reg;
    logic [RW+1:0]   srem_reg;
    logic [RW-1:0]   root_reg;
    logic [DENW:0]   dt;
    logic            dge;
    logic [RW+3:0]   st, trial;
    logic            sge;

    assign status.div_last  = (step_reg == SW'(DVW - 1));
    assign status.sqrt_last = (step_reg == SW'(RW - 1));

    assign dt    = {rem_reg[DENW-1:0], dvd_reg[DVW-1]};
    assign dge   = dt >= {1'b0, den_reg};
    assign st    = {srem_reg, dvd_reg[DVW-1:DVW-2]};
    assign trial = {(RW+2)'(root_reg), 2'b01};
    assign sge   = st >= trial;

    always_ff @(posedge clk)
    begin
        if (cmd.num)
        begin
            dvd_reg  <= {num, 16'd0};
            rem_reg  <= '0;
            srem_reg <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.div)
        begin
            rem_reg  <= dge ? dt - {1'b0, den_reg} : dt;
            dvd_reg  <= {dvd_reg[DVW-2:0], dge};
            step_reg <= status.div_last ? '0 : step_reg + SW'(1);
        end
        else if (cmd.sqrt)
        begin
            srem_reg <= (RW+2)'(sge ? st - trial : st);
            root_reg <= {root_reg[RW-2:0], sge};
            dvd_reg  <= {dvd_reg[DVW-3:0], 2'b00};
            step_reg <= step_reg + SW'(1);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data.window_count <= (MW'(n_reg) > MW'(CNT_SAT)) ? CNT_SAT : 10'(n_reg);
            out_data.std_dev_q8   <= (|root_reg[RW-1:24]) ? SD_SAT : root_reg[23:0];
            out_data.std_valid    <= ok_reg;
        end
    end

endmodule

### rtl/wisd_checker.sv
// ----------------------------------------------------------------------------
// wisd_checker
// Port-level checks for the windowed interval deviation block.
// ----------------------------------------------------------------------------
module wisd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input wisd_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input wisd_pkg::out_item_t out_data
);
    import wisd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_measure_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation == OP_MEASURE |=> !in_ready)
        else $error("ready after measure accept");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.std_valid |-> out_data.std_dev_q8 == 24'd0)
        else $error("invalid result carries deviation");

    a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.window_count < 10'd2 |-> out_data.std_dev_q8 == 24'd0)
        else $error("deviation with fewer than two samples");

endmodule

bind windowed_interval_std_dev wisd_checker u_wisd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
